>>> hw/rtl/i2cbs_pkg.sv
// ============================================================================
// i2cbs_pkg: shared types and constants of the I2C master bit sequencer
// Command codes, the decoded item that passes from the front part to the
// back part, and the stream payload widths.
// ============================================================================
package i2cbs_pkg;

  localparam int unsigned KindW      = 3;
  localparam int unsigned InTdataW   = 16;
  localparam int unsigned OutTdataW  = 16;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  typedef enum logic [KindW-1:0] {
    CMD_NONE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_WRITE    = 3'd3,
    CMD_READ     = 3'd4,
    CMD_SEND_ACK = 3'd5,
    CMD_RECV_ACK = 3'd6
  } cmd_e;

  // One decoded tick: the command (idle when none), the value that seeds the
  // shift register when the command starts, and the sampled SDA level.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] seed;
    logic       sda_line;
  } item_t;

endpackage

>>> hw/rtl/i2c_master_bit_sequencer_unit.sv
// ============================================================================
// i2c_master_bit_sequencer_unit: I2C master pin sequencer
// Turns a stream of ticks, each optionally carrying a bus command, into a
// stream of SCL/SDA drive levels and status, one result per tick.
// ============================================================================
// Every input transaction is one tick and yields exactly one output
// transaction. A tick that arrives while the sequencer is idle may start a
// command (start, stop, write byte, read byte, send ack, receive ack); the
// command then performs one pin write per tick, starting on the tick that
// carries it, and a command that arrives while one is still running is
// dropped and reported as rejected. The block takes one transaction per
// clock and delivers one per clock when the output side keeps up: the back
// part performs one pin step per tick and registers its result as the tick
// leaves the two-entry queue, so an unstalled tick passes through a queue
// entry and then the output register from input to output. The queue lets the
// input side keep running for two more transactions while the output is stalled.
module i2c_master_bit_sequencer_unit import i2cbs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // Fields from bit 0 up: data_byte [7:0], ack_bit [8], sda_line [9], zero fill.
  input  logic [InTdataW-1:0]  s_axis_tdata,
  // Fields: kind [2:0].
  input  logic [KindW-1:0]     s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // Fields from bit 0 up: scl_out [0], sda_out [1], busy_res [2], done_res [3],
  // rx_byte [11:4], rx_ack [12], rejected [13], zero fill.
  output logic [OutTdataW-1:0] m_axis_tdata
);

  logic  push, full, pop, q_valid;
  item_t front_item, q_item;

  // The front part decodes the tick so the queue carries only what the
  // sequencer needs.
  i2cbs_front u_front (
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .s_kind_i  (s_axis_tuser),
    .push_o    (push),
    .item_o    (front_item),
    .full_i    (full)
  );

  i2cbs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // The back part owns all bus state and the output register.
  i2cbs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata)
  );

`ifndef SYNTHESIS
  // A completed command is always reported as busy on the same tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[3]) |-> m_axis_tdata[2])
    else $error("done reported without busy");

  // A command can only be rejected while a sequence is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[13]) |-> m_axis_tdata[2])
    else $error("rejected reported while idle");

  // The queue only fills up behind a result that is waiting to be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");
`endif

endmodule

>>> hw/rtl/i2cbs_front.sv
// ============================================================================
// i2cbs_front: input acceptance and command decode
// Unpacks the input stream, maps unused codes to no command and picks the
// shift seed so that the back part sees one narrow decoded item.
// ============================================================================
module i2cbs_front import i2cbs_pkg::*; (
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  logic [InTdataW-1:0] s_data_i,
  input  logic [KindW-1:0]    s_kind_i,
  output logic                push_o,
  output item_t               item_o,
  input  logic                full_i
);

  logic [7:0] data_byte;
  logic       ack_bit;
  logic       is_cmd;

  assign data_byte = s_data_i[7:0];
  assign ack_bit   = s_data_i[8];
  assign s_ready_o = ~full_i;
  assign push_o    = s_valid_i & ~full_i;

  always_comb begin
    is_cmd = (s_kind_i >= KindW'(CMD_START)) && (s_kind_i <= KindW'(CMD_RECV_ACK));
    item_o.cmd      = is_cmd ? cmd_e'(s_kind_i) : CMD_NONE;
    item_o.sda_line = s_data_i[9];
    case (item_o.cmd)
      CMD_WRITE:    item_o.seed = data_byte;
      CMD_SEND_ACK: item_o.seed = {7'd0, ack_bit};
      default:      item_o.seed = 8'd0;
    endcase
  end

endmodule

>>> hw/rtl/i2cbs_queue.sv
// ============================================================================
// i2cbs_queue: short decoupling queue
// A small first-in first-out buffer of decoded items between front and back.
// ============================================================================
module i2cbs_queue import i2cbs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t                entry_q [QueueDepth];
  logic [QueueAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueueAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueueAw:0]     count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == (QueueAw+1)'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = entry_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> hw/rtl/i2cbs_back.sv
// ============================================================================
// i2cbs_back: pin sequencer and result register
// Performs one pin step per decoded item and holds the packed result until
// the output side takes it.
// ============================================================================
module i2cbs_back import i2cbs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  item_t                q_item_i,
  output logic                 pop_o,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output logic [OutTdataW-1:0] m_data_o
);

  cmd_e       active_q, active_d, cmd_eff;
  logic [1:0] phase_q, phase_d, phase_eff;
  logic [2:0] bit_q, bit_d, bit_eff;
  logic [7:0] shift_q, shift_d, shift_eff;
  logic       scl_q, scl_d, sda_q, sda_d;
  logic [7:0] rx_byte_q, rx_byte_d;
  logic       rx_ack_q, rx_ack_d;
  logic       busy, done, rejected;
  logic                 out_valid_q;
  logic [OutTdataW-1:0] out_data_q;

  assign pop_o     = q_valid_i & (~out_valid_q | m_ready_i);
  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;

  always_comb begin
    cmd_eff   = active_q;
    phase_eff = phase_q;
    bit_eff   = bit_q;
    shift_eff = shift_q;
    rejected  = 1'b0;
    if (active_q != CMD_NONE) begin
      rejected = (q_item_i.cmd != CMD_NONE);
    end else if (q_item_i.cmd != CMD_NONE) begin
      cmd_eff   = q_item_i.cmd;
      phase_eff = 2'd0;
      bit_eff   = 3'd0;
      shift_eff = q_item_i.seed;
    end

    active_d  = cmd_eff;
    phase_d   = phase_eff + 2'd1;
    bit_d     = bit_eff;
    shift_d   = shift_eff;
    scl_d     = scl_q;
    sda_d     = sda_q;
    rx_byte_d = rx_byte_q;
    rx_ack_d  = rx_ack_q;
    done      = 1'b0;
    busy      = (cmd_eff != CMD_NONE);

    case (cmd_eff)
      CMD_START: begin
        case (phase_eff)
          2'd0:    sda_d = 1'b1;
          2'd1:    scl_d = 1'b1;
          2'd2:    sda_d = 1'b0;
          default: begin
            scl_d = 1'b0;
            done  = 1'b1;
          end
        endcase
      end
      CMD_STOP: begin
        case (phase_eff)
          2'd0:    sda_d = 1'b0;
          2'd1:    scl_d = 1'b1;
          default: begin
            sda_d = 1'b1;
            done  = 1'b1;
          end
        endcase
      end
      CMD_WRITE: begin
        case (phase_eff)
          2'd0:    sda_d = shift_eff[~bit_eff];
          2'd1:    scl_d = 1'b1;
          default: begin
            scl_d = 1'b0;
            if (bit_eff == 3'd7) begin
              done = 1'b1;
            end else begin
              phase_d = 2'd0;
              bit_d   = bit_eff + 3'd1;
            end
          end
        endcase
      end
      CMD_READ: begin
        case (phase_eff)
          2'd0:    sda_d = 1'b1;
          2'd1:    scl_d = 1'b1;
          default: begin
            scl_d   = 1'b0;
            shift_d = {shift_eff[6:0], q_item_i.sda_line};
            if (bit_eff == 3'd7) begin
              rx_byte_d = shift_d;
              done      = 1'b1;
            end else begin
              phase_d = 2'd1;
              bit_d   = bit_eff + 3'd1;
            end
          end
        endcase
      end
      CMD_SEND_ACK: begin
        case (phase_eff)
          2'd0:    sda_d = shift_eff[0];
          2'd1:    scl_d = 1'b1;
          default: begin
            scl_d = 1'b0;
            done  = 1'b1;
          end
        endcase
      end
      CMD_RECV_ACK: begin
        case (phase_eff)
          2'd0:    sda_d = 1'b1;
          2'd1:    scl_d = 1'b1;
          default: begin
            scl_d    = 1'b0;
            rx_ack_d = q_item_i.sda_line;
            done     = 1'b1;
          end
        endcase
      end
      default: phase_d = 2'd0;
    endcase

    if (done) begin
      active_d = CMD_NONE;
      phase_d  = 2'd0;
      bit_d    = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= CMD_NONE;
      phase_q     <= 2'd0;
      bit_q       <= 3'd0;
      shift_q     <= 8'd0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      rx_byte_q   <= 8'd0;
      rx_ack_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        active_q  <= active_d;
        phase_q   <= phase_d;
        bit_q     <= bit_d;
        shift_q   <= shift_d;
        scl_q     <= scl_d;
        sda_q     <= sda_d;
        rx_byte_q <= rx_byte_d;
        rx_ack_q  <= rx_ack_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result fields from bit 0 up: scl, sda, busy, done, rx byte, rx ack, rejected.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_data_q <= {2'b00, rejected, rx_ack_d, rx_byte_d, done, busy, sda_d, scl_d};
    end
  end

endmodule
